@@ rtl/core/md5_pkg.sv @@
package md5_pkg;

  // Initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] PAD_WORD = 32'h00000080;

  // Default depth of the queue between front and back
  localparam int Q_DEPTH_DEF = 4;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic [31:0] word;    // masked, with the 0x80 byte merged in on a short last word
    logic [2:0]  nbytes;  // message bytes in the word, 0..4
    logic        last;
  } md5_item_t;

  // Per-round additive constants
  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {group, round[1:0]}
  function automatic logic [4:0] md5_rot(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/md5_front.sv @@
module md5_front import md5_pkg::*; #(
  parameter int QDepth = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_final_word,
  output logic        q_valid,
  output md5_item_t   q_item,
  input  logic        q_pop
);

  localparam int PW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CW = $clog2(QDepth + 1);

  md5_item_t       mem [QDepth];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   cnt_r;
  md5_item_t       cls;
  logic            push;

  // Classify: clip byte count, mask unused bytes, merge the 0x80 marker
  always_comb begin
    cls.last = in_final_word;
    if (!in_final_word || in_byte_count >= 3'd4) begin
      cls.nbytes = 3'd4;
      cls.word   = in_message_word;
    end else begin
      cls.nbytes = in_byte_count;
      case (in_byte_count[1:0])
        2'd0:    cls.word = PAD_WORD;
        2'd1:    cls.word = {16'h0, 8'h80, in_message_word[7:0]};
        2'd2:    cls.word = {8'h0, 8'h80, in_message_word[15:0]};
        default: cls.word = {8'h80, in_message_word[23:0]};
      endcase
    end
  end

  assign in_stall = (cnt_r == CW'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem[rptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QDepth - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (q_pop) begin
        rptr_r <= (rptr_r == PW'(QDepth - 1)) ? '0 : rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(q_pop);
    end
  end

endmodule

@@ rtl/core/md5_back.sv @@
module md5_back import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  md5_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_digest_index,
  output logic        out_digest_last
);

  typedef enum logic [4:0] {
    S_FILL  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    P_MARK = 3'b001,
    P_ZERO = 3'b010,
    P_HIGH = 3'b100
  } pstep_t;

  state_t      state_r, state_nxt;
  pstep_t      pstep_r, pstep_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] work_r [4];
  logic [31:0] work_nxt [4];
  logic [31:0] blk [16];
  logic [63:0] len_r, len_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        pad_r, pad_nxt;
  logic        done_r, done_nxt;
  logic        push;
  logic [31:0] push_word;

  // Round datapath
  logic [1:0]  grp;
  logic [3:0]  g;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    grp = rnd_r[5:4];
    case (grp)
      2'd0: begin
        f = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
        g = rnd_r[3:0];
      end
      2'd1: begin
        f = (work_r[3] & work_r[1]) | (~work_r[3] & work_r[2]);
        g = 4'(rnd_r[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = work_r[1] ^ work_r[2] ^ work_r[3];
        g = 4'(rnd_r[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = work_r[2] ^ (work_r[1] | ~work_r[3]);
        g = 4'(rnd_r[3:0] * 4'd7);
      end
    endcase
    sum = work_r[0] + f + md5_k(rnd_r) + blk[g];
    s   = md5_rot({grp, rnd_r[1:0]});
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pstep_nxt = pstep_r;
    chain_nxt = chain_r;
    work_nxt  = work_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    pad_nxt   = pad_r;
    done_nxt  = done_r;
    push      = 1'b0;
    push_word = q_item.word;
    q_pop     = 1'b0;

    case (state_r)
      S_FILL: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          push    = 1'b1;
          len_nxt = len_r + {58'h0, q_item.nbytes, 3'b000};
          if (q_item.last) begin
            pad_nxt   = 1'b1;
            pstep_nxt = (q_item.nbytes == 3'd4) ? P_MARK : P_ZERO;
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        push = 1'b1;
        case (pstep_r)
          P_MARK: begin
            push_word = PAD_WORD;
            pstep_nxt = P_ZERO;
          end
          P_ZERO: begin
            if (fill_r == 4'd14) begin
              push_word = len_r[31:0];
              pstep_nxt = P_HIGH;
            end else begin
              push_word = '0;
            end
          end
          P_HIGH: begin
            push_word = len_r[63:32];
            done_nxt  = 1'b1;
          end
          default: push_word = '0;
        endcase
      end
      S_ROUND: begin
        work_nxt[0] = work_r[3];
        work_nxt[1] = work_r[1] + rot;
        work_nxt[2] = work_r[1];
        work_nxt[3] = work_r[2];
        rnd_nxt     = rnd_r + 1'b1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < 4; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        state_nxt = done_r ? S_OUT : (pad_r ? S_PAD : S_FILL);
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 2'd3) begin
            chain_nxt = '{IV_A, IV_B, IV_C, IV_D};
            len_nxt   = '0;
            pad_nxt   = 1'b0;
            done_nxt  = 1'b0;
            state_nxt = S_FILL;
          end
        end
      end
      default: state_nxt = S_FILL;
    endcase

    // Buffer write; a full block starts compression
    if (push) begin
      fill_nxt = fill_r + 1'b1;
      if (fill_r == 4'd15) begin
        work_nxt  = chain_r;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
    end
  end

  // Block buffer
  always_ff @(posedge clk) begin
    if (push) begin
      blk[fill_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      pstep_r <= P_ZERO;
      chain_r <= '{IV_A, IV_B, IV_C, IV_D};
      work_r  <= '{default: '0};
      len_r   <= '0;
      fill_r  <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      pad_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pstep_r <= pstep_nxt;
      chain_r <= chain_nxt;
      work_r  <= work_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      pad_r   <= pad_nxt;
      done_r  <= done_nxt;
    end
  end

  // Digest words come straight from the chaining registers
  assign out_valid        = (state_r == S_OUT);
  assign out_digest_word  = chain_r[idx_r];
  assign out_digest_index = idx_r;
  assign out_digest_last  = (idx_r == 2'd3);

  // Compression only runs on a freshly completed block
  a_round_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> fill_r == 4'd0)
    else $error("round running with partial block");

  a_add_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> $past(state_r == S_ROUND && rnd_r == 6'd63))
    else $error("chain update without 64 rounds");

  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_FILL && q_valid)
    else $error("queue popped outside fill");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> done_r && fill_r == 4'd0)
    else $error("digest out before padding finished");

endmodule

@@ rtl/core/md5_hash_engine.sv @@
// Channel  | Dir | Ports                                               | Handshake
// in_      | in  | message_word[31:0], byte_count[2:0], final_word     | in_valid / in_stall
// out_     | out | digest_word[31:0], digest_index[1:0], digest_last   | out_valid / out_stall
//
// A 16-word block is filled from the queue, then compressed in 64 rounds and a chain add;
// the single shared round unit sets the throughput.
// A final word adds padding words plus up to two more compressions,
// then the four digest words, each held while out_stall is high.
// Reset (synchronous, rst_n low) loads the initial chain and clears counters.
// Until full, the input queue takes items while the core computes or the digest is stalled.
module md5_hash_engine import md5_pkg::*; #(
  parameter int QDepth = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_digest_index,
  output logic        out_digest_last
);

  logic      q_valid;
  logic      q_pop;
  md5_item_t q_item;

  md5_front #(.QDepth(QDepth)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_byte_count   (in_byte_count),
    .in_final_word   (in_final_word),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  md5_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digest_word  (out_digest_word),
    .out_digest_index (out_digest_index),
    .out_digest_last  (out_digest_last)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import md5_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_WORDS = 480;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_message_word;
  logic [2:0]  in_byte_count;
  logic        in_final_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [1:0]  out_digest_index;
  logic        out_digest_last;

  md5_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_message_word(in_message_word), .in_byte_count(in_byte_count),
    .in_final_word(in_final_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_digest_index(out_digest_index),
    .out_digest_last(out_digest_last)
  );

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_t;

  // Predictor state
  logic [31:0] chain_q [4];
  logic [31:0] blk_q [16];
  logic [63:0] msg_bits;
  int          fill_ptr;
  digest_t     digest_fifo [$];
  int          fail_cnt;
  int          cycle_cnt;

  // Stimulus table row
  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic        has_dig;
    logic [31:0] dig [4];
  } stim_row_t;

  // RFC 1321 sine table
  function automatic logic [31:0] sine_const(input int r);
    logic [31:0] t [64];
    t = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[r];
  endfunction

  // One 64-round compression of blk_q into chain_q
  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, sum, tmp;
    int g, grp, sh;
    int shifts [16];
    shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int r = 0; r < 64; r++) begin
      grp = r / 16;
      case (grp)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (d & b) | (~d & c); g = 5 * r + 1; end
        2: begin f = b ^ c ^ d; g = 3 * r + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * r; end
      endcase
      g = g % 16;
      sh = shifts[grp * 4 + r % 4];
      sum = a + f + sine_const(r) + blk_q[g];
      tmp = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = tmp;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endtask

  task automatic md5_push(input logic [31:0] w);
    blk_q[fill_ptr] = w;
    fill_ptr = (fill_ptr + 1) % 16;
    if (fill_ptr == 0) md5_compress();
  endtask

  task automatic md5_restart();
    chain_q[0] = IV_A; chain_q[1] = IV_B; chain_q[2] = IV_C; chain_q[3] = IV_D;
    msg_bits = '0;
    fill_ptr = 0;
  endtask

  // Absorb one accepted item; a final word queues four digest words
  task automatic md5_absorb(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    int n;
    logic [31:0] mask;
    digest_t dg;
    if (!fin) begin
      msg_bits += 64'd32;
      md5_push(w);
    end else begin
      n = (nb > 3'd4) ? 4 : int'(nb);
      msg_bits += 64'(n * 8);
      if (n == 4) begin
        md5_push(w);
        md5_push(PAD_WORD);
      end else begin
        mask = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
        md5_push((w & mask) | (PAD_WORD << (8 * n)));
      end
      while (fill_ptr != 14) md5_push(32'h0);
      md5_push(msg_bits[31:0]);
      md5_push(msg_bits[63:32]);
      for (int i = 0; i < 4; i++) begin
        dg.word = chain_q[i];
        dg.index = 2'(i);
        dg.last = (i == 3);
        digest_fifo.push_back(dg);
      end
      md5_restart();
    end
  endtask

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall pattern: phases of heavy, light and no stalling
  int stall_mode;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Digest checker
  always @(posedge clk) begin
    digest_t exp_d;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_fifo.size() == 0) begin
        $error("digest word with none expected: %h", out_digest_word);
        fail_cnt++;
      end else begin
        exp_d = digest_fifo.pop_front();
        if (out_digest_word !== exp_d.word) begin
          $error("digest_word exp %h got %h", exp_d.word, out_digest_word);
          fail_cnt++;
        end
        if (out_digest_index !== exp_d.index) begin
          $error("digest_index exp %0d got %0d", exp_d.index, out_digest_index);
          fail_cnt++;
        end
        if (out_digest_last !== exp_d.last) begin
          $error("digest_last exp %0d got %0d", exp_d.last, out_digest_last);
          fail_cnt++;
        end
      end
    end
  end

  // Drive one item, holding it until accepted; then update the predictor
  task automatic send_item(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    in_valid <= 1'b1;
    in_message_word <= w;
    in_byte_count <= nb;
    in_final_word <= fin;
    do @(posedge clk); while (in_stall);
    md5_absorb(w, nb, fin);
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  stim_row_t rows [$];

  task automatic add_row(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    stim_row_t r;
    r.word = w; r.nbytes = nb; r.last = fin; r.has_dig = 1'b0;
    rows.push_back(r);
  endtask

  task automatic add_known(input logic [31:0] w, input logic [2:0] nb,
                           input logic [31:0] d0, input logic [31:0] d1,
                           input logic [31:0] d2, input logic [31:0] d3);
    stim_row_t r;
    r.word = w; r.nbytes = nb; r.last = 1'b1; r.has_dig = 1'b1;
    r.dig = '{d0, d1, d2, d3};
    rows.push_back(r);
  endtask

  initial begin
    int burst, words_left, nwords, msg_cnt;
    logic [2:0] nb;
    stim_row_t r;
    fail_cnt = 0;
    cycle_cnt = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_message_word = '0;
    in_byte_count = '0;
    in_final_word = 1'b0;
    out_stall = 1'b0;
    md5_restart();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "a", "abc" (known digests)
    add_known(32'h0, 3'd0, 32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec);
    add_known(32'h00000061, 3'd1, 32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769);
    add_known(32'h00636261, 3'd3, 32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128);
    // Short non-final word counted as four bytes, then final with four bytes
    add_row(32'hffffffff, 3'd1, 1'b0);
    add_row(32'h00000000, 3'd4, 1'b1);
    // Byte count above four on a final word
    add_row(32'ha5a5a5a5, 3'd7, 1'b1);
    add_row(32'h5a5a5a5a, 3'd5, 1'b1);
    // Fifteen words: padding spills into a second block
    for (int i = 0; i < 14; i++) add_row(32'hffffffff, 3'd4, 1'b0);
    add_row(32'hffffffff, 3'd2, 1'b1);
    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.word, r.nbytes, r.last);
      if (r.has_dig) begin
        for (int k = 0; k < 4; k++)
          if (digest_fifo[digest_fifo.size() - 4 + k].word !== r.dig[k]) begin
            $error("digest_word table exp %h model %h", r.dig[k],
                   digest_fifo[digest_fifo.size() - 4 + k].word);
            fail_cnt++;
          end
      end
    end
    idle_cycles(1);

    // Pause until every digest word has drained
    while (digest_fifo.size() != 0) @(posedge clk);

    // Random messages, mostly short, some spanning several blocks
    words_left = RANDOM_WORDS;
    msg_cnt = 0;
    burst = $urandom_range(1, 20);
    while (words_left > 0) begin
      nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 6);
      msg_cnt++;
      for (int i = 0; i <= nwords; i++) begin
        if (i == nwords) nb = 3'($urandom_range(0, 7));
        else nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
        send_item($urandom, nb, i == nwords);
        words_left--;
        if (--burst == 0) begin
          burst = $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
        end
      end
      if (msg_cnt % 25 == 0) begin
        idle_cycles(1);
        while (digest_fifo.size() != 0) @(posedge clk);
      end
    end
    idle_cycles(1);

    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/md5_pkg.sv
rtl/core/md5_front.sv
rtl/core/md5_back.sv
rtl/core/md5_hash_engine.sv
dv/testbench.sv
